// File: design/ufea_pkg.sv
// ----------------------------------------------------------------------------
// ufea_pkg: shared types and microcode for the union-find edge acceptor
// Item structs, control word layout, sequencer steps and the control store.
// ----------------------------------------------------------------------------
package ufea_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 1024;
  localparam int unsigned VTX_W    = 10;
  localparam int unsigned WEIGHT_W = 24;
  localparam int unsigned TOTAL_W  = 48;
  localparam int unsigned COUNT_W  = 10;
  localparam int unsigned VCNT_W   = 11;
  localparam int unsigned RANK_W   = 4;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  localparam logic [RANK_W-1:0]  RANK_INIT = RANK_W'(1);
  localparam logic [RANK_W-1:0]  RANK_MAX  = RANK_W'(15);
  localparam logic [VCNT_W-1:0]  VCNT_RESET = VCNT_W'(1024);

  // register index, taken from paddr[2]
  localparam logic REG_VERTEX_COUNT = 1'b0;

  typedef struct packed {
    logic [VTX_W-1:0]           vertex_a;
    logic [VTX_W-1:0]           vertex_b;
    logic signed [WEIGHT_W-1:0] edge_weight;
  } in_item_t;

  typedef struct packed {
    logic                      joined;
    logic                      bad_vertex;
    logic signed [TOTAL_W-1:0] tree_weight;
    logic [COUNT_W-1:0]        edges_taken;
    logic                      tree_complete;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FA_RD,
    ST_FA_CHK,
    ST_CA_SET,
    ST_CA_RD,
    ST_CA_WR,
    ST_FB_SET,
    ST_FB_RD,
    ST_FB_CHK,
    ST_CB_SET,
    ST_CB_RD,
    ST_CB_WR,
    ST_SAME,
    ST_LINK,
    ST_RANK,
    ST_EMIT
  } step_t;

  typedef enum logic [1:0] {X_HOLD, X_A, X_B, X_PARENT} x_sel_t;
  typedef enum logic [1:0] {M_NONE, M_COMP, M_LINK, M_RANK} mem_op_t;
  typedef enum logic [2:0] {
    C_ALWAYS, C_ACCEPT, C_BAD, C_ROOT, C_AT_ROOT, C_SAME, C_OUT_FREE
  } cond_t;

  typedef struct packed {
    logic    take;      // ready for a new item
    x_sel_t  x_sel;
    logic    root_b;    // 0: root register A, 1: root register B
    logic    ld_root;
    mem_op_t mem_op;
    logic    tot;       // bump weight total and edge count
    logic    emit;
  } ctrl_t;

  typedef struct packed {
    logic accept;
    logic bad;
    logic is_root;
    logic at_root;
    logic same;
    logic out_free;
  } stat_t;

  typedef struct packed {
    ctrl_t ctrl;
    cond_t cond;
    step_t jmp;   // taken when cond holds
    step_t alt;   // taken otherwise
  } uword_t;

  function automatic uword_t mk(input ctrl_t c, input cond_t cd, input step_t j,
                                input step_t a);
    uword_t w;
    w.ctrl = c;
    w.cond = cd;
    w.jmp  = j;
    w.alt  = a;
    return w;
  endfunction

  // control store
  function automatic uword_t ucode(input step_t pc);
    ctrl_t c;
    uword_t w;
    c = '{take: 1'b0, x_sel: X_HOLD, root_b: 1'b0, ld_root: 1'b0,
          mem_op: M_NONE, tot: 1'b0, emit: 1'b0};
    case (pc)
      ST_IDLE: begin
        c.take = 1'b1;
        w = mk(c, C_ACCEPT, ST_CHECK, ST_IDLE);
      end
      ST_CHECK: begin
        c.x_sel = X_A;
        w = mk(c, C_BAD, ST_EMIT, ST_FA_RD);
      end
      ST_FA_RD:  w = mk(c, C_ALWAYS, ST_FA_CHK, ST_FA_CHK);
      ST_FA_CHK: begin
        c.ld_root = 1'b1;
        c.x_sel   = X_PARENT;
        w = mk(c, C_ROOT, ST_CA_SET, ST_FA_RD);
      end
      ST_CA_SET: begin
        c.x_sel = X_A;
        w = mk(c, C_ALWAYS, ST_CA_RD, ST_CA_RD);
      end
      ST_CA_RD:  w = mk(c, C_ALWAYS, ST_CA_WR, ST_CA_WR);
      ST_CA_WR: begin
        c.mem_op = M_COMP;
        c.x_sel  = X_PARENT;
        w = mk(c, C_AT_ROOT, ST_FB_SET, ST_CA_RD);
      end
      ST_FB_SET: begin
        c.x_sel = X_B;
        w = mk(c, C_ALWAYS, ST_FB_RD, ST_FB_RD);
      end
      ST_FB_RD:  w = mk(c, C_ALWAYS, ST_FB_CHK, ST_FB_CHK);
      ST_FB_CHK: begin
        c.root_b  = 1'b1;
        c.ld_root = 1'b1;
        c.x_sel   = X_PARENT;
        w = mk(c, C_ROOT, ST_CB_SET, ST_FB_RD);
      end
      ST_CB_SET: begin
        c.x_sel = X_B;
        w = mk(c, C_ALWAYS, ST_CB_RD, ST_CB_RD);
      end
      ST_CB_RD:  w = mk(c, C_ALWAYS, ST_CB_WR, ST_CB_WR);
      ST_CB_WR: begin
        c.root_b = 1'b1;
        c.mem_op = M_COMP;
        c.x_sel  = X_PARENT;
        w = mk(c, C_AT_ROOT, ST_SAME, ST_CB_RD);
      end
      ST_SAME:   w = mk(c, C_SAME, ST_EMIT, ST_LINK);
      ST_LINK: begin
        c.mem_op = M_LINK;
        c.tot    = 1'b1;
        w = mk(c, C_ALWAYS, ST_RANK, ST_RANK);
      end
      ST_RANK: begin
        c.mem_op = M_RANK;
        w = mk(c, C_ALWAYS, ST_EMIT, ST_EMIT);
      end
      ST_EMIT: begin
        c.emit = 1'b1;
        w = mk(c, C_OUT_FREE, ST_IDLE, ST_EMIT);
      end
      default:   w = mk(c, C_ALWAYS, ST_IDLE, ST_IDLE);
    endcase
    return w;
  endfunction

endpackage

// File: design/ufea_ram.sv
// ----------------------------------------------------------------------------
// ufea_ram: generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ufea_ram #(
  parameter int unsigned WIDTH = 14,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/ufea_seq.sv
// ----------------------------------------------------------------------------
// ufea_seq: microcode sequencer
// Step counter, control store lookup and two-way conditional jump.
// ----------------------------------------------------------------------------
module ufea_seq import ufea_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ctrl_t ctrl
);

  step_t  pc;
  step_t  pc_next;
  uword_t word;
  logic   cond_ok;

  assign word = ucode(pc);
  assign ctrl = word.ctrl;

  always_comb begin
    case (word.cond)
      C_ALWAYS:   cond_ok = 1'b1;
      C_ACCEPT:   cond_ok = stat.accept;
      C_BAD:      cond_ok = stat.bad;
      C_ROOT:     cond_ok = stat.is_root;
      C_AT_ROOT:  cond_ok = stat.at_root;
      C_SAME:     cond_ok = stat.same;
      C_OUT_FREE: cond_ok = stat.out_free;
      default:    cond_ok = 1'b1;
    endcase
    pc_next = cond_ok ? word.jmp : word.alt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// File: design/ufea_datapath.sv
// ----------------------------------------------------------------------------
// ufea_datapath: forest memory, walk registers, totals and result register
// Parent and rank share one RAM word; a clearing pass seeds it after reset.
// ----------------------------------------------------------------------------
module ufea_datapath import ufea_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ctrl_t             ctrl,
  output stat_t             stat,
  input  logic [VCNT_W-1:0] limit,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item
);

  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned MW = AW + RANK_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_VERTICES - 1);

  logic                      cleared;
  logic [AW-1:0]             clr_idx;
  logic [AW-1:0]             va, vb, x;
  logic [AW-1:0]             ra, rb;
  logic [RANK_W-1:0]         rka, rkb;
  logic                      bad;
  logic                      joined;
  logic signed [WEIGHT_W-1:0] weight;
  logic signed [TOTAL_W-1:0] weight_total;
  logic [COUNT_W-1:0]        accepted_count;

  logic              in_fire;
  logic              in_bad;
  logic [MW-1:0]     rdata;
  logic [AW-1:0]     rd_parent;
  logic [RANK_W-1:0] rd_rank;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [MW-1:0]     wdata;
  logic [AW-1:0]     lo, hi;
  logic [RANK_W-1:0] rank_lo, rank_hi;
  logic              out_free;
  logic              complete;

  assign rd_parent = rdata[MW-1:RANK_W];
  assign rd_rank   = rdata[RANK_W-1:0];

  assign in_stall = !(ctrl.take && cleared);
  assign in_fire  = in_valid && !in_stall;
  assign in_bad   = ({1'b0, in_item.vertex_a} >= limit) ||
                    ({1'b0, in_item.vertex_b} >= limit);
  assign out_free = !out_valid || !out_stall;

  // lower-rank root goes under the other; on a tie A's root goes under B's
  assign lo      = (rka > rkb) ? rb : ra;
  assign hi      = (rka > rkb) ? ra : rb;
  assign rank_lo = (rka > rkb) ? rkb : rka;
  assign rank_hi = (rka > rkb) ? rka : rkb;

  assign complete = (limit != '0) &&
                    ({1'b0, accepted_count} == (limit - VCNT_W'(1)));

  assign stat.accept   = in_fire;
  assign stat.bad      = bad;
  assign stat.is_root  = (rd_parent == x);
  assign stat.at_root  = (x == (ctrl.root_b ? rb : ra));
  assign stat.same     = (ra == rb);
  assign stat.out_free = out_free;

  always_comb begin
    we    = 1'b0;
    waddr = x;
    wdata = {x, rd_rank};
    if (!cleared) begin
      we    = 1'b1;
      waddr = clr_idx;
      wdata = {clr_idx, RANK_INIT};
    end else begin
      case (ctrl.mem_op)
        M_COMP: begin
          // rewriting the root onto itself is harmless
          we    = 1'b1;
          waddr = x;
          wdata = {(ctrl.root_b ? rb : ra), rd_rank};
        end
        M_LINK: begin
          we    = 1'b1;
          waddr = lo;
          wdata = {hi, rank_lo};
        end
        M_RANK: begin
          we    = (rank_lo == rank_hi) && (rank_hi != RANK_MAX);
          waddr = hi;
          wdata = {hi, rank_hi + RANK_W'(1)};
        end
        default: we = 1'b0;
      endcase
    end
  end

  ufea_ram #(
    .WIDTH (MW),
    .DEPTH (MAX_VERTICES)
  ) u_forest (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (x),
    .rdata (rdata)
  );

  // clearing pass and control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      cleared        <= 1'b0;
      clr_idx        <= '0;
      weight_total   <= '0;
      accepted_count <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (!cleared) begin
        clr_idx <= clr_idx + AW'(1);
        if (clr_idx == LAST_IDX) begin
          cleared <= 1'b1;
        end
      end
      if (ctrl.tot) begin
        weight_total   <= weight_total + TOTAL_W'(weight);
        accepted_count <= accepted_count + COUNT_W'(1);
      end
      if (ctrl.emit && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      va     <= AW'(in_item.vertex_a);
      vb     <= AW'(in_item.vertex_b);
      weight <= in_item.edge_weight;
      bad    <= in_bad;
      joined <= 1'b0;
    end else if (ctrl.tot) begin
      joined <= 1'b1;
    end
    case (ctrl.x_sel)
      X_A:      x <= va;
      X_B:      x <= vb;
      X_PARENT: x <= rd_parent;
      default:  x <= x;
    endcase
    if (ctrl.ld_root) begin
      if (ctrl.root_b) begin
        rb  <= x;
        rkb <= rd_rank;
      end else begin
        ra  <= x;
        rka <= rd_rank;
      end
    end
    if (ctrl.emit && out_free) begin
      out_item.joined        <= joined;
      out_item.bad_vertex    <= bad;
      out_item.tree_weight   <= weight_total;
      out_item.edges_taken   <= accepted_count;
      out_item.tree_complete <= complete;
    end
  end

endmodule

// File: design/union_find_edge_acceptor_unit.sv
// ----------------------------------------------------------------------------
// union_find_edge_acceptor_unit: Kruskal edge acceptor on a disjoint-set forest
// Union by rank with full path compression, running weight total and count.
// ----------------------------------------------------------------------------
//  channel  | signals                               | direction
//  ---------+---------------------------------------+----------
//  input    | in_valid, in_stall, in_item           | edge items in
//  output   | out_valid, out_stall, out_item        | result items out
//  config   | psel penable pwrite paddr pwdata ...  | vertex_count register
//
//  A merging item walks and compresses the path from each end to its root, then
//  links and ranks; a shared root skips both, a bad vertex goes straight to emit.
//  Each find or compression step is one access to the single forest RAM.
//  After reset a clearing pass seeds every one of the MAX_VERTICES forest entries,
//  with in_stall high; configuration writes are taken throughout.
//  A stalled result waits in the output register; the sequencer holds there.
// ----------------------------------------------------------------------------
module union_find_edge_acceptor_unit import ufea_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item
);

  localparam int unsigned VMAX_CAP =
      (MAX_VERTICES > 2047) ? 2047 : MAX_VERTICES;

  logic [VCNT_W-1:0] vertex_count;
  logic [VCNT_W-1:0] limit;
  ctrl_t             ctrl;
  stat_t             stat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_VERTEX_COUNT) ?
                  APB_DW'(vertex_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCNT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_VERTEX_COUNT) begin
      vertex_count <= pwdata[VCNT_W-1:0];
    end
  end

  assign limit = (vertex_count < VCNT_W'(VMAX_CAP)) ? vertex_count
                                                    : VCNT_W'(VMAX_CAP);

  ufea_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  ufea_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .stat      (stat),
    .limit     (limit),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
